>>> src/slru_pkg.sv
// ----------------------------------------------------------------------------
// slru_pkg
// Shared widths, constants and sequencer state codes for the LRU cache model.
// ----------------------------------------------------------------------------
package slru_pkg;

  localparam int ADDR_W    = 31;
  localparam int CFG_W     = 2;

  // largest legal associativity code, higher codes saturate to it
  localparam logic [CFG_W-1:0] WAYS_LG_MAX = 2'd2;

  typedef enum logic [10:0] {
    S_CLEAR = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_MOD   = 11'b000_0000_0100,
    S_FILL  = 11'b000_0000_1000,
    S_FCAP  = 11'b000_0001_0000,
    S_RD    = 11'b000_0010_0000,
    S_CMP   = 11'b000_0100_0000,
    S_SRD   = 11'b000_1000_0000,
    S_SWR   = 11'b001_0000_0000,
    S_LAST  = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } seq_state_t;

endpackage

>>> src/slru_ifs.sv
// ----------------------------------------------------------------------------
// slru_ifs
// Valid/ready channel interfaces for lookup requests and lookup results.
// ----------------------------------------------------------------------------
interface slru_req_if;
  import slru_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] block_address;

  modport source (output valid, output block_address, input ready);
  modport sink   (input valid, input block_address, output ready);
endinterface

interface slru_rsp_if;
  import slru_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] echo_address;
  logic              hit;

  modport source (output valid, output echo_address, output hit, input ready);
  modport sink   (input valid, input echo_address, input hit, output ready);
endinterface

>>> src/slru_ram.sv
// ----------------------------------------------------------------------------
// slru_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module slru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/slru_mod.sv
// ----------------------------------------------------------------------------
// slru_mod
// Set index stage: remainder by a power-of-two set count, registered and valid the cycle after start.
// ----------------------------------------------------------------------------
module slru_mod #(
  parameter int DIV_W = 9
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [slru_pkg::ADDR_W-1:0] dividend,
  input  logic [DIV_W-1:0]            divisor,
  output logic                        done,
  output logic [DIV_W-1:0]            rem
);
  import slru_pkg::*;

  logic             busy_r, busy_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;

  always_comb begin
    busy_nxt = start;
    rem_nxt  = rem_r;
    if (start) begin
      // set count is always a power of two, so the remainder is the low bits
      rem_nxt = dividend[DIV_W-1:0] & (divisor - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    rem_r <= rem_nxt;
  end

  assign done = busy_r;
  assign rem  = rem_r;

endmodule

>>> src/set_assoc_lru_cache_model.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model
// Set-associative block address cache with 1, 2 or 4 ways and LRU order.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  in_req    in   valid/ready    block_address[30:0]
//  out_rsp   out  valid/ready    echo_address[30:0], hit
//  cfg_*     in   cfg_we         cfg_wdata[1:0] = ways_log2
//
//  One lookup holds the block through S_MOD, S_FILL and S_FCAP, then S_RD and S_CMP
//  for each probe and S_SRD and S_SWR for each shift, with S_LAST when a hit or an
//  eviction rewrites the most recent entry, then S_DONE. The set index is the address
//  masked by the set count minus one (TOTAL_LINES is a power of two); probes and
//  shifts use the line RAM. After reset and after every cfg write a clearing pass over
//  all TOTAL_LINES fill entries zeroes the fill counts; in_req is not ready meanwhile.
//  The result waits in an output register; a new transaction is taken meanwhile,
//  and the next result holds in its last state while that register stays full.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_model #(
  parameter int TOTAL_LINES = 256,
  parameter int MAX_WAYS    = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  slru_req_if.sink                   in_req,
  slru_rsp_if.source                 out_rsp,
  input  logic                       cfg_we,
  input  logic [slru_pkg::CFG_W-1:0] cfg_wdata
);
  import slru_pkg::*;

  localparam int IDX_W   = $clog2(TOTAL_LINES);
  localparam int CNT_W   = $clog2(TOTAL_LINES + 1);
  localparam int LG_WAYS = $clog2(MAX_WAYS + 1) - 1;
  localparam int LG_LINE = $clog2(TOTAL_LINES + 1) - 1;
  localparam int LG_CAP0 = (LG_WAYS < LG_LINE) ? LG_WAYS : LG_LINE;
  localparam int LG_CAP  = (LG_CAP0 < 2) ? LG_CAP0 : 2;
  localparam int WMAX    = 1 << LG_CAP;
  localparam int FILL_W  = $clog2(WMAX + 1);
  localparam int SUM_W   = IDX_W + FILL_W;

  seq_state_t         state_r, state_nxt;
  logic [CFG_W-1:0]   lg_r, lg_nxt;
  logic [CNT_W-1:0]   clr_r, clr_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [IDX_W-1:0]   set_r, set_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [FILL_W-1:0]  idx_r, idx_nxt;
  logic               hit_r, hit_nxt;
  logic               ovalid_r, ovalid_nxt;
  logic [ADDR_W-1:0]  oaddr_r, oaddr_nxt;
  logic               ohit_r, ohit_nxt;

  logic [CFG_W-1:0]   lg_clip;
  logic [CFG_W-1:0]   lg_eff;
  logic [FILL_W-1:0]  ways;
  logic [CNT_W-1:0]   sets;
  logic [SUM_W-1:0]   base;
  logic [FILL_W-1:0]  rd_off, wr_off;
  logic [SUM_W-1:0]   rd_sum, wr_sum;

  logic               mod_start, mod_done;
  logic [CNT_W-1:0]   mod_rem;

  logic               fill_we;
  logic [IDX_W-1:0]   fill_waddr;
  logic [FILL_W-1:0]  fill_wdata, fill_rdata;
  logic               line_we;
  logic [ADDR_W-1:0]  line_wdata, line_rdata;

  logic [FILL_W-1:0]  cur_fill;
  logic [FILL_W-1:0]  fcap;

  // effective associativity, saturated and capped by the build limits
  assign lg_clip = (lg_r > WAYS_LG_MAX) ? WAYS_LG_MAX : lg_r;
  assign lg_eff  = (lg_clip > CFG_W'(LG_CAP)) ? CFG_W'(LG_CAP) : lg_clip;
  assign ways    = FILL_W'(1) << lg_eff;
  assign sets    = CNT_W'(TOTAL_LINES) >> lg_eff;
  assign base    = SUM_W'(set_r) << lg_eff;
  assign rd_sum  = base + SUM_W'(rd_off);
  assign wr_sum  = base + SUM_W'(wr_off);
  assign fcap    = (fill_rdata > ways) ? ways : fill_rdata;

  slru_mod #(.DIV_W(CNT_W)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (addr_nxt),
    .divisor  (sets),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  slru_ram #(.WIDTH(FILL_W), .DEPTH(TOTAL_LINES)) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .raddr (set_r),
    .rdata (fill_rdata)
  );

  slru_ram #(.WIDTH(ADDR_W), .DEPTH(TOTAL_LINES)) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (wr_sum[IDX_W-1:0]),
    .wdata (line_wdata),
    .raddr (rd_sum[IDX_W-1:0]),
    .rdata (line_rdata)
  );

  assign in_req.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    lg_nxt     = lg_r;
    clr_nxt    = clr_r;
    addr_nxt   = addr_r;
    set_nxt    = set_r;
    fill_nxt   = fill_r;
    idx_nxt    = idx_r;
    hit_nxt    = hit_r;
    ovalid_nxt = ovalid_r;
    oaddr_nxt  = oaddr_r;
    ohit_nxt   = ohit_r;
    mod_start  = 1'b0;
    fill_we    = 1'b0;
    fill_waddr = set_r;
    fill_wdata = '0;
    line_we    = 1'b0;
    line_wdata = addr_r;
    rd_off     = idx_r;
    wr_off     = idx_r;
    cur_fill   = fill_r;

    if (ovalid_r && out_rsp.ready) begin
      ovalid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        fill_we    = 1'b1;
        fill_waddr = clr_r[IDX_W-1:0];
        if (clr_r == CNT_W'(TOTAL_LINES - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_req.valid) begin
          addr_nxt  = in_req.block_address;
          mod_start = 1'b1;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          set_nxt   = mod_rem[IDX_W-1:0];
          state_nxt = S_FILL;
        end
      end
      S_FILL: begin
        state_nxt = S_FCAP;
      end
      S_FCAP, S_CMP: begin
        if (state_r == S_FCAP) begin
          cur_fill = fcap;
          fill_nxt = fcap;
          idx_nxt  = '0;
        end
        if (state_r == S_CMP && line_rdata == addr_r) begin
          // hit: slide the younger entries down over it
          hit_nxt   = 1'b1;
          state_nxt = ({1'b0, idx_r} + 1'b1 < {1'b0, fill_r}) ? S_SRD : S_LAST;
        end else if (state_r == S_FCAP && fcap != '0) begin
          state_nxt = S_RD;
        end else if (state_r == S_CMP && {1'b0, idx_r} + 1'b1 < {1'b0, fill_r}) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_RD;
        end else begin
          hit_nxt = 1'b0;
          if (cur_fill < ways) begin
            // free way in the set: append as most recent
            line_we    = 1'b1;
            wr_off     = cur_fill;
            fill_we    = 1'b1;
            fill_wdata = cur_fill + 1'b1;
            state_nxt  = S_DONE;
          end else begin
            // full set: evict position zero
            idx_nxt   = '0;
            state_nxt = (cur_fill > FILL_W'(1)) ? S_SRD : S_LAST;
          end
        end
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_SRD: begin
        rd_off    = idx_r + 1'b1;
        state_nxt = S_SWR;
      end
      S_SWR: begin
        line_we    = 1'b1;
        line_wdata = line_rdata;
        idx_nxt    = idx_r + 1'b1;
        state_nxt  = ({1'b0, idx_r} + 2'd2 < {1'b0, fill_r}) ? S_SRD : S_LAST;
      end
      S_LAST: begin
        line_we   = 1'b1;
        wr_off    = fill_r - 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!ovalid_r || out_rsp.ready) begin
          ovalid_nxt = 1'b1;
          oaddr_nxt  = addr_r;
          ohit_nxt   = hit_r;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
        clr_nxt   = '0;
      end
    endcase

    // a new associativity invalidates the whole cache
    if (cfg_we) begin
      lg_nxt    = cfg_wdata;
      clr_nxt   = '0;
      state_nxt = S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      lg_r     <= '0;
      clr_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      lg_r     <= lg_nxt;
      clr_r    <= clr_nxt;
      ovalid_r <= ovalid_nxt;
    end
    addr_r  <= addr_nxt;
    set_r   <= set_nxt;
    fill_r  <= fill_nxt;
    idx_r   <= idx_nxt;
    hit_r   <= hit_nxt;
    oaddr_r <= oaddr_nxt;
    ohit_r  <= ohit_nxt;
  end

  assign out_rsp.valid        = ovalid_r;
  assign out_rsp.echo_address = oaddr_r;
  assign out_rsp.hit          = ohit_r;

endmodule

>>> bench/lru_lookup_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_lookup_checker
// Watches the lookup request, lookup result and cfg ports of the LRU cache,
// keeps its own copy of the tag store and per-set fill counts, and compares
// each result transaction with the oldest predicted lookup outcome.
// ----------------------------------------------------------------------------
module lru_lookup_checker #(
  parameter int TOTAL_LINES = 256,
  parameter int MAX_WAYS    = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [slru_pkg::ADDR_W-1:0] in_block_address,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [slru_pkg::ADDR_W-1:0] out_echo_address,
  input  logic                        out_hit,
  input  logic                        cfg_we,
  input  logic [slru_pkg::CFG_W-1:0]  cfg_wdata,
  output int                          errors,
  output int                          outstanding,
  output int                          lookups_done,
  output int                          hits_done
);
  import slru_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              hit;
  } lookup_result_t;

  lookup_result_t    pending_lookups[$];
  logic [ADDR_W-1:0] tag_store [TOTAL_LINES];
  int                set_fill [TOTAL_LINES];
  logic [CFG_W-1:0]  assoc_code;
  int                err_cnt;
  int                result_cnt;
  int                hit_cnt;
  lookup_result_t    want;
  logic              predicted_hit;

  function automatic int assoc_ways(input logic [CFG_W-1:0] code);
    int lg;
    int w;
    lg = (code > WAYS_LG_MAX) ? int'(WAYS_LG_MAX) : int'(code);
    w  = 1 << lg;
    while (w > 1 && (w > MAX_WAYS || w > TOTAL_LINES)) w = w >> 1;
    return w;
  endfunction

  // in each set, position 0 is least recent and fill-1 most recent
  task automatic predict_lookup(input logic [ADDR_W-1:0] addr, output logic hit);
    int ways;
    int sets;
    int set_idx;
    int base;
    int fill;
    int pos;
    int i;
    ways = assoc_ways(assoc_code);
    sets = TOTAL_LINES / ways;
    if (sets == 0) sets = 1;
    set_idx = int'(addr % ADDR_W'(sets));
    base    = set_idx * ways;
    fill    = set_fill[set_idx];
    if (fill > ways) fill = ways;
    pos = -1;
    for (i = 0; i < fill; i++) begin
      if (pos < 0 && tag_store[base + i] == addr) pos = i;
    end
    if (pos >= 0) begin
      for (i = pos; i + 1 < fill; i++) tag_store[base + i] = tag_store[base + i + 1];
      tag_store[base + fill - 1] = addr;
    end else if (fill < ways) begin
      tag_store[base + fill] = addr;
      set_fill[set_idx]      = fill + 1;
    end else begin
      // evict the least recent line
      for (i = 0; i + 1 < fill; i++) tag_store[base + i] = tag_store[base + i + 1];
      tag_store[base + fill - 1] = addr;
    end
    hit = (pos >= 0);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pending_lookups.delete();
      foreach (set_fill[i]) set_fill[i] = 0;
      assoc_code = '0;
      err_cnt    = 0;
      result_cnt = 0;
      hit_cnt    = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_lookups.size() == 0) begin
          $display("%0t: result transaction with nothing expected: addr %h hit %0b",
                   $time, out_echo_address, out_hit);
          err_cnt++;
        end else begin
          want = pending_lookups.pop_front();
          if (out_echo_address !== want.address) begin
            $display("%0t: echo_address mismatch: expected %h, actual %h",
                     $time, want.address, out_echo_address);
            err_cnt++;
          end
          if (out_hit !== want.hit) begin
            $display("%0t: hit mismatch for addr %h: expected %0b, actual %0b",
                     $time, want.address, want.hit, out_hit);
            err_cnt++;
          end
          result_cnt++;
          if (want.hit) hit_cnt++;
        end
      end
      // a new associativity invalidates the whole cache
      if (cfg_we) begin
        assoc_code = cfg_wdata;
        foreach (set_fill[i]) set_fill[i] = 0;
      end
      if (in_valid && in_ready) begin
        predict_lookup(in_block_address, predicted_hit);
        pending_lookups.push_back({in_block_address, predicted_hit});
      end
    end
    errors       <= err_cnt;
    outstanding  <= pending_lookups.size();
    lookups_done <= result_cnt;
    hits_done    <= hit_cnt;
  end

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives block address lookups through the LRU cache under all associativity
// codes, with sender gaps, result stalls and a long result hold-off; the
// checker beside the block predicts every hit/miss and reports the verdict.
// ----------------------------------------------------------------------------
module tb;
  import slru_pkg::*;

  localparam int TOTAL_LINES = 256;
  localparam int MAX_WAYS    = 4;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 100;
  localparam int RECENT_MAX  = 8;

  localparam logic [CFG_W-1:0] WAYS_ONE       = 2'd0;
  localparam logic [CFG_W-1:0] WAYS_TWO       = 2'd1;
  localparam logic [CFG_W-1:0] WAYS_FOUR      = 2'd2;
  localparam logic [CFG_W-1:0] WAYS_SATURATED = 2'd3;

  localparam logic [ADDR_W-1:0] ONE_WAY_SEQ [10] = '{
    31'h0, 31'h0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd256,
    31'h0, 31'd255, 31'h7FFF_FF00, 31'h5555_5555, 31'h2AAA_AAAA
  };
  // all but the last in set 0 with 64 sets: fill, hit reorder, then LRU evictions
  localparam logic [ADDR_W-1:0] FOUR_WAY_SEQ [10] = '{
    31'd0, 31'd64, 31'd128, 31'd192, 31'd0,
    31'd256, 31'd64, 31'd0, 31'd192, 31'h7FFF_FFFF
  };

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  slru_req_if req ();
  slru_rsp_if rsp ();

  int errors;
  int outstanding;
  int lookups_done;
  int hits_done;

  int tx_idle_pct;
  int rx_idle_pct;
  int hold_reqs;
  int hold_seen;
  int hold_left;

  logic [ADDR_W-1:0] recent_addrs[$];
  logic [ADDR_W-1:0] tag_base;

  set_assoc_lru_cache_model #(
    .TOTAL_LINES (TOTAL_LINES),
    .MAX_WAYS    (MAX_WAYS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req),
    .out_rsp   (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  lru_lookup_checker #(
    .TOTAL_LINES (TOTAL_LINES),
    .MAX_WAYS    (MAX_WAYS)
  ) chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (req.valid),
    .in_ready         (req.ready),
    .in_block_address (req.block_address),
    .out_valid        (rsp.valid),
    .out_ready        (rsp.ready),
    .out_echo_address (rsp.echo_address),
    .out_hit          (rsp.hit),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .errors           (errors),
    .outstanding      (outstanding),
    .lookups_done     (lookups_done),
    .hits_done        (hits_done)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // result side: random stalls, or a counted hold-off when one is requested
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      rsp.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  initial begin
    #1_500_000;
    $display("TB_ERROR");
    $finish;
  end

  // returns at the edge where the transaction was taken, valid still high
  task automatic send_lookup(input logic [ADDR_W-1:0] addr);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid         <= 1'b1;
    req.block_address <= addr;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_ways(input logic [CFG_W-1:0] code);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= code;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tag_base  = ADDR_W'($urandom()) & ~ADDR_W'(TOTAL_LINES - 1);
    recent_addrs.delete();
  endtask

  // mostly a few conflicting tags per set plus reuse, so hits and evictions are common
  function automatic logic [ADDR_W-1:0] pick_address();
    logic [ADDR_W-1:0] a;
    int                sel;
    sel = $urandom_range(0, 99);
    if (sel < 55)
      a = tag_base + ADDR_W'($urandom_range(0, 5) * TOTAL_LINES + $urandom_range(0, 15));
    else if (sel < 85 && recent_addrs.size() > 0)
      a = recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
    else
      a = ADDR_W'($urandom());
    recent_addrs.push_back(a);
    if (recent_addrs.size() > RECENT_MAX) void'(recent_addrs.pop_front());
    return a;
  endfunction

  task automatic run_random(input int count);
    repeat (count) send_lookup(pick_address());
  endtask

  initial begin
    rst_n             = 1'b0;
    req.valid         = 1'b0;
    req.block_address = '0;
    rsp.ready         = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = WAYS_ONE;
    tx_idle_pct       = 0;
    rx_idle_pct       = 0;
    tag_base          = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset associativity: direct mapped
    foreach (ONE_WAY_SEQ[i]) send_lookup(ONE_WAY_SEQ[i]);

    // unused code saturates to four ways
    set_ways(WAYS_SATURATED);
    foreach (FOUR_WAY_SEQ[i]) send_lookup(FOUR_WAY_SEQ[i]);
    // rewriting the same code still invalidates everything
    set_ways(WAYS_SATURATED);
    send_lookup(31'd0);
    send_lookup(31'd64);

    set_ways(WAYS_TWO);
    tx_idle_pct = 26;
    rx_idle_pct = 49;
    run_random(250);

    set_ways(WAYS_FOUR);
    tx_idle_pct = 49;
    rx_idle_pct = 26;
    run_random(120);
    wait_drained();
    run_random(130);

    set_ways(WAYS_ONE);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // sender keeps offering while results are held back
    hold_reqs++;
    run_random(200);

    set_ways(WAYS_SATURATED);
    run_random(50);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d lookups (%0d hits) over all four associativity codes,",
             lookups_done, hits_done);
    $display("with sender gaps, result stalls and a %0d-cycle result hold-off",
             HOLD_CYCLES);
    if (errors == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
src/slru_pkg.sv
src/slru_ifs.sv
src/slru_ram.sv
src/slru_mod.sv
src/set_assoc_lru_cache_model.sv
bench/lru_lookup_checker.sv
bench/tb.sv
